>>> src/frmb_pkg.sv
// Shared types, constants and the CRC-16 byte step for the request frame builder.
`default_nettype none
package frmb_pkg;

  localparam int MAX_WRITE_VALUES = 123;
  localparam int VL_W             = 7;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = 2;
  localparam int QCNT_W           = 3;

  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FN_WRITE_MULTI  = 8'h10;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  // What the serializer has to do for one accepted item.
  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_READ,
    KIND_WOPEN,
    KIND_WCONT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        closes;
    logic [7:0]  addr;
    logic [15:0] first;
    logic [15:0] count;
    logic [15:0] value;
  } cmd_t;

  // One byte through the reflected CRC-16, one bit per step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/modbus_request_frame_builder.sv
// Top level of the Modbus RTU request frame builder with streaming CRC-16.
// An accepted item waits in the command queue, then each of its beats is loaded into the serializer's output register.
// Throughput: one output beat per cycle while out_tready is high; an item produces 1 to 11 bytes, one beat per
// byte, through the single byte lane of the serializer. A four-entry queue lets input run ahead.
// Reset (synchronous, active low): no frame open, CRC at 0xFFFF, slave address 1, queue empty.
`default_nettype none
module modbus_request_frame_builder
  import frmb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: slave address.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // Input items.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [15:0] first_register, [31:16] register_count,
                                       // [47:32] value
  input  wire logic [0:0]  in_tuser,   // [0] command
  // Result beats.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] frame_byte
  output logic             out_tlast,  // last beat caused by one input item
  output logic [1:0]       out_tuser   // [0] end_of_frame, [1] error
);

  // The user must write the slave address register only while the block is idle (the block
  // does not enforce it), so the front end can stamp it into each command as it is accepted.
  logic [7:0] slave_addr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'h01;
    end else if (cfg_valid && cfg_ready) begin
      slave_addr_r <= cfg_data;
    end
  end

  logic push, q_full, q_valid, pop;
  cmd_t push_cmd, q_cmd;
  logic out_eof, out_err;

  // The front end decides what each item means and keeps the write frame state.
  frmb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .slave_addr (slave_addr_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_command (in_tuser[0]),
    .in_first   (in_tdata[15:0]),
    .in_count   (in_tdata[31:16]),
    .in_value   (in_tdata[47:32]),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  frmb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  // The serializer walks each command byte by byte and owns the running CRC,
  // which carries across the items of one write frame.
  frmb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_eof   (out_eof),
    .out_err   (out_err)
  );

  assign out_tuser = {out_err, out_eof};

endmodule
`default_nettype wire

>>> src/frmb_front.sv
// Front end: accepts items, tracks the open write frame and classifies each item.
`default_nettype none
module frmb_front
  import frmb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  slave_addr,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [15:0] in_first,
  input  wire logic [15:0] in_count,
  input  wire logic [15:0] in_value,
  output logic             push,
  output cmd_t             push_cmd,
  input  wire logic        q_full
);

  logic            wopen_r, wopen_nxt;
  logic [VL_W-1:0] vl_r, vl_nxt;
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  always_comb begin
    wopen_nxt         = wopen_r;
    vl_nxt            = vl_r;
    push_cmd.kind     = KIND_ERR;
    push_cmd.closes   = 1'b0;
    push_cmd.addr     = slave_addr;
    push_cmd.first    = in_first;
    push_cmd.count    = in_count;
    push_cmd.value    = in_value;
    if (!in_command) begin
      // A read may not interleave with an open write frame.
      if (!wopen_r) begin
        push_cmd.kind   = KIND_READ;
        push_cmd.closes = 1'b1;
      end
    end else if (!wopen_r) begin
      if (in_count != 16'd0 && in_count <= 16'(MAX_WRITE_VALUES)) begin
        push_cmd.kind   = KIND_WOPEN;
        push_cmd.closes = (in_count == 16'd1);
        vl_nxt          = in_count[VL_W-1:0] - VL_W'(1);
        wopen_nxt       = (in_count != 16'd1);
      end
    end else begin
      push_cmd.kind   = KIND_WCONT;
      push_cmd.closes = (vl_r == VL_W'(1));
      vl_nxt          = vl_r - VL_W'(1);
      wopen_nxt       = (vl_r != VL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wopen_r <= 1'b0;
      vl_r    <= '0;
    end else if (accept) begin
      wopen_r <= wopen_nxt;
      vl_r    <= vl_nxt;
    end
  end

  // The frame is open exactly while values are still owed.
  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    wopen_r == (vl_r != '0))
    else $error("write_open disagrees with values_left");

  // A rejected item never changes the frame state.
  a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && push_cmd.kind == KIND_ERR |=> $stable(wopen_r) && $stable(vl_r))
    else $error("error item changed frame state");

endmodule
`default_nettype wire

>>> src/frmb_queue.sv
// Short command queue between the front end and the serializer.
`default_nettype none
module frmb_queue
  import frmb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      q_valid,
  output cmd_t      q_cmd,
  input  wire logic pop
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> src/frmb_back.sv
// Back end: serializes queued commands into bytes with the running CRC-16.
`default_nettype none
module frmb_back
  import frmb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire cmd_t       q_cmd,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_eof,
  output logic            out_err
);

  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        ov_r;
  logic [7:0]  byte_r;
  logic        last_r, eof_r, err_r;

  logic        load;
  logic [3:0]  n_data;
  logic [7:0]  data_byte, cur_byte;
  logic        is_lo, is_hi, is_last;

  assign load = q_valid && (!ov_r || out_ready);

  always_comb begin
    case (q_cmd.kind)
      KIND_READ:  n_data = 4'd6;
      KIND_WOPEN: n_data = 4'd9;
      KIND_WCONT: n_data = 4'd2;
      default:    n_data = 4'd1;
    endcase
  end

  always_comb begin
    data_byte = 8'h00;
    case (q_cmd.kind)
      KIND_READ, KIND_WOPEN: begin
        case (idx_r)
          4'd0:    data_byte = q_cmd.addr;
          4'd1:    data_byte = (q_cmd.kind == KIND_READ) ? FN_READ_HOLDING : FN_WRITE_MULTI;
          4'd2:    data_byte = q_cmd.first[15:8];
          4'd3:    data_byte = q_cmd.first[7:0];
          4'd4:    data_byte = q_cmd.count[15:8];
          4'd5:    data_byte = q_cmd.count[7:0];
          4'd6:    data_byte = {q_cmd.count[6:0], 1'b0};
          4'd7:    data_byte = q_cmd.value[15:8];
          4'd8:    data_byte = q_cmd.value[7:0];
          default: data_byte = 8'h00;
        endcase
      end
      KIND_WCONT: begin
        data_byte = idx_r[0] ? q_cmd.value[7:0] : q_cmd.value[15:8];
      end
      default: data_byte = 8'h00;
    endcase
  end

  always_comb begin
    is_lo = (q_cmd.kind != KIND_ERR) && q_cmd.closes && (idx_r == n_data);
    is_hi = (q_cmd.kind != KIND_ERR) && q_cmd.closes && (idx_r == n_data + 4'd1);
    if (q_cmd.kind == KIND_ERR) begin
      is_last = 1'b1;
    end else if (q_cmd.closes) begin
      is_last = is_hi;
    end else begin
      is_last = (idx_r == n_data - 4'd1);
    end
    if (is_lo) begin
      cur_byte = crc_r[7:0];
    end else if (is_hi) begin
      cur_byte = crc_r[15:8];
    end else begin
      cur_byte = data_byte;
    end
    crc_nxt = crc_r;
    if (is_hi) begin
      crc_nxt = CRC_INIT;
    end else if (!is_lo && q_cmd.kind != KIND_ERR) begin
      crc_nxt = crc_byte(crc_r, data_byte);
    end
    idx_nxt = is_last ? 4'd0 : idx_r + 4'd1;
  end

  assign pop       = load && is_last;
  assign out_valid = ov_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_eof   = eof_r;
  assign out_err   = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
      crc_r <= CRC_INIT;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= idx_nxt;
        crc_r <= crc_nxt;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= is_last;
      eof_r  <= is_hi;
      err_r  <= (q_cmd.kind == KIND_ERR);
    end
  end

  // The CRC starts over once a frame has been closed.
  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load && is_hi |=> crc_r == CRC_INIT)
    else $error("CRC not restarted after frame end");

  // An error beat is a lone zero byte that ends its run and no frame.
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && err_r |-> last_r && !eof_r && byte_r == 8'h00)
    else $error("malformed error beat");

  // The frame end is always the last beat of its run.
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && eof_r |-> last_r)
    else $error("frame end not at end of run");

endmodule
`default_nettype wire
